// ===== src/tlmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Tank level median filter package
// Shared types, register indexes and reset constants of the level filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tlmf_pkg;

  localparam int unsigned DistW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned FracW   = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [DistW-1:0] FullDistanceRst   = 16'd0;
  localparam logic [DistW-1:0] EmptyDistanceRst  = 16'd0;
  localparam logic [DistW-1:0] TankCapacityRst   = 16'd0;
  localparam logic [DistW-1:0] MinDistanceRst    = 16'd0;
  localparam logic [DistW-1:0] MaxDistanceRst    = 16'hFFFF;
  localparam logic [TimeW-1:0] FreshnessLimitRst = 32'd60000;

  localparam logic [FracW-1:0] FractionOne = 17'h10000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFullDistance   = 3'd0,
    CfgEmptyDistance  = 3'd1,
    CfgTankCapacity   = 3'd2,
    CfgMinDistance    = 3'd3,
    CfgMaxDistance    = 3'd4,
    CfgFreshnessLimit = 3'd5
  } cfg_index_e;

  typedef enum logic [1:0] {
    StatusValid  = 2'd0,
    StatusStale  = 2'd1,
    StatusUnavail = 2'd2
  } level_status_e;

  typedef enum logic [1:0] {
    FracZero = 2'd0,
    FracOne  = 2'd1,
    FracDiv  = 2'd2
  } frac_mode_e;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             sample_present;
    logic             sample_finite;
    logic [TimeW-1:0] time_ms;
  } tlmf_in_t;

  typedef struct packed {
    logic             accepted;
    level_status_e    level_status;
    logic [DistW-1:0] filtered_distance;
    logic             level_known;
    logic [FracW-1:0] fill_fraction;
    logic [DistW-1:0] volume;
  } tlmf_out_t;

  typedef struct packed {
    logic [DistW-1:0] full_distance;
    logic [DistW-1:0] empty_distance;
    logic [DistW-1:0] tank_capacity;
    logic [DistW-1:0] min_distance;
    logic [DistW-1:0] max_distance;
    logic [TimeW-1:0] freshness_limit;
  } tlmf_cfg_t;

  typedef struct packed {
    logic             accepted;
    level_status_e    level_status;
    logic [DistW-1:0] filtered;
    logic             known;
    frac_mode_e       mode;
    logic [DistW-1:0] numer;
    logic [DistW-1:0] denom;
  } tlmf_job_t;

endpackage

`default_nettype wire

// ===== src/tlmf_front.sv =====
// ----------------------------------------------------------------------------
// Tank level filter front end
// Qualifies samples, keeps the three-entry window, forms the median (the single
// sample or pair mean before that) and freshness status, and queues a fraction job.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmf_front
  import tlmf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tlmf_cfg_t cfg_i,
  input  wire logic      take_i,
  input  wire tlmf_in_t  in_data_i,
  output tlmf_job_t      job_o
);

  logic [DistW-1:0] window_q [3];
  logic [DistW-1:0] window_n [3];
  logic [1:0]       write_slot_q, write_slot_d;
  logic [1:0]       held_q, held_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [DistW-1:0] filt_q, filt_d;

  logic             in_ok;
  logic [1:0]       slot;
  logic [DistW-1:0] lo, hi, med;
  logic [DistW:0]   pair_sum;
  logic [TimeW-1:0] elapsed;
  logic             cal_ok;
  logic             known;

  always_comb begin
    in_ok = in_data_i.sample_present && in_data_i.sample_finite &&
            (in_data_i.distance >= cfg_i.min_distance) &&
            (in_data_i.distance <= cfg_i.max_distance);
    slot  = (write_slot_q < 2'd3) ? write_slot_q : 2'd0;

    for (int i = 0; i < 3; i++) begin
      window_n[i] = (in_ok && (slot == 2'(i))) ? in_data_i.distance : window_q[i];
    end

    write_slot_d = in_ok ? ((slot == 2'd2) ? 2'd0 : slot + 2'd1) : write_slot_q;
    held_d       = (in_ok && (held_q != 2'd3)) ? held_q + 2'd1 : held_q;
    last_d       = in_ok ? in_data_i.time_ms : last_q;

    lo       = (window_n[0] < window_n[1]) ? window_n[0] : window_n[1];
    hi       = (window_n[0] < window_n[1]) ? window_n[1] : window_n[0];
    med      = (window_n[2] <= lo) ? lo : ((window_n[2] >= hi) ? hi : window_n[2]);
    pair_sum = {1'b0, window_n[0]} + {1'b0, window_n[1]};

    if (!in_ok) begin
      filt_d = filt_q;
    end else if (held_d == 2'd1) begin
      filt_d = window_n[0];
    end else if (held_d == 2'd2) begin
      filt_d = pair_sum[DistW:1];
    end else begin
      filt_d = med;
    end

    cal_ok  = cfg_i.full_distance < cfg_i.empty_distance;
    known   = (held_d != 2'd0) && cal_ok;
    elapsed = in_data_i.time_ms - last_d;

    job_o.accepted = in_ok;
    job_o.filtered = filt_d;
    job_o.known    = known;
    job_o.numer    = cfg_i.empty_distance - filt_d;
    job_o.denom    = cfg_i.empty_distance - cfg_i.full_distance;

    if (!known) begin
      job_o.level_status = StatusUnavail;
    end else if (elapsed > cfg_i.freshness_limit) begin
      job_o.level_status = StatusStale;
    end else begin
      job_o.level_status = StatusValid;
    end

    if (!known || (filt_d >= cfg_i.empty_distance)) begin
      job_o.mode = FracZero;
    end else if (filt_d <= cfg_i.full_distance) begin
      job_o.mode = FracOne;
    end else begin
      job_o.mode = FracDiv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= 2'd0;
      held_q       <= 2'd0;
      last_q       <= '0;
      filt_q       <= '0;
    end else if (take_i) begin
      write_slot_q <= write_slot_d;
      held_q       <= held_d;
      last_q       <= last_d;
      filt_q       <= filt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      for (int i = 0; i < 3; i++) begin
        window_q[i] <= window_n[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tlmf_queue.sv =====
// ----------------------------------------------------------------------------
// Tank level filter job queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmf_queue
  import tlmf_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire tlmf_job_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output tlmf_job_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tlmf_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o     = (count_q == CntW'(Depth));
    valid_o    = (count_q != '0);
    pop_data_o = mem_q[rd_ptr_q];
    do_push    = push_i && !full_o;
    do_pop     = pop_i && valid_o;

    wr_ptr_d = wr_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    rd_ptr_d = rd_ptr_q;
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/tlmf_back.sv =====
// ----------------------------------------------------------------------------
// Tank level filter back end
// Serial restoring divider for the fill fraction, volume multiply and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmf_back
  import tlmf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [DistW-1:0] tank_capacity_i,
  input  wire logic             job_valid_i,
  input  wire tlmf_job_t        job_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tlmf_out_t             out_data_o
);

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SDiv  = 4'b0010,
    SMul  = 4'b0100,
    SOut  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  tlmf_job_t        job_q;
  logic [DistW-1:0] rem_q, rem_d;
  logic [DistW-1:0] quot_q, quot_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [FracW-1:0] frac_q, frac_d;
  tlmf_out_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             load;

  logic [DistW:0]       rem_shift;
  logic                 rem_ge;
  logic [DistW:0]       rem_sub;
  logic [FracW+DistW-1:0] prod;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    frac_d      = frac_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    load        = 1'b0;

    rem_shift = {rem_q, 1'b0};
    rem_ge    = rem_shift >= {1'b0, job_q.denom};
    rem_sub   = rem_shift - {1'b0, job_q.denom};
    prod      = frac_q * tank_capacity_i;

    case (state_q)
      SIdle: begin
        if (job_valid_i) begin
          load   = 1'b1;
          rem_d  = job_i.numer;
          quot_d = '0;
          cnt_d  = '0;
          if (job_i.mode == FracDiv) begin
            state_d = SDiv;
          end else begin
            frac_d  = (job_i.mode == FracOne) ? FractionOne : '0;
            state_d = SMul;
          end
        end
      end
      SDiv: begin
        rem_d  = rem_ge ? rem_sub[DistW-1:0] : rem_shift[DistW-1:0];
        quot_d = {quot_q[DistW-2:0], rem_ge};
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          frac_d  = {1'b0, quot_d};
          state_d = SMul;
        end
      end
      SMul: begin
        out_d.accepted          = job_q.accepted;
        out_d.level_status      = job_q.level_status;
        out_d.filtered_distance = job_q.filtered;
        out_d.level_known       = job_q.known;
        out_d.fill_fraction     = frac_q;
        out_d.volume            = prod[DistW+15:16];
        out_valid_d             = 1'b1;
        state_d                 = SOut;
      end
      SOut: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d     = SIdle;
        out_valid_d = 1'b0;
      end
    endcase
  end

  assign job_pop_o   = load;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    rem_q  <= rem_d;
    quot_q <= quot_d;
    frac_q <= frac_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// ===== src/tank_level_median_filter.sv =====
// ----------------------------------------------------------------------------
// Tank level median filter
// Median-of-three distance filter with freshness status, fill fraction and
// volume for a tank level sensor.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i/in_stall_o   tlmf_in_t
//   out       output     out_valid_o/out_stall_i tlmf_out_t
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// Each item goes through the queue to the back end; a fraction that is not 0 or
// 1 first needs the 16-step serial divider. The back end takes one job at a
// time; the front end and the queue (two entries by default) accept items while
// it works. Reset is asynchronous and needs no clearing pass. A stalled output
// holds its result and stops the back end; the input stalls once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_level_median_filter
  import tlmf_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tlmf_in_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tlmf_out_t               out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  tlmf_cfg_t cfg_q;
  tlmf_job_t front_job;
  tlmf_job_t queue_job;
  logic      queue_full;
  logic      queue_valid;
  logic      queue_pop;
  logic      take;

  assign in_stall_o = queue_full;
  assign take       = in_valid_i && !queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_distance   <= FullDistanceRst;
      cfg_q.empty_distance  <= EmptyDistanceRst;
      cfg_q.tank_capacity   <= TankCapacityRst;
      cfg_q.min_distance    <= MinDistanceRst;
      cfg_q.max_distance    <= MaxDistanceRst;
      cfg_q.freshness_limit <= FreshnessLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgFullDistance:   cfg_q.full_distance   <= cfg_data_i[DistW-1:0];
        CfgEmptyDistance:  cfg_q.empty_distance  <= cfg_data_i[DistW-1:0];
        CfgTankCapacity:   cfg_q.tank_capacity   <= cfg_data_i[DistW-1:0];
        CfgMinDistance:    cfg_q.min_distance    <= cfg_data_i[DistW-1:0];
        CfgMaxDistance:    cfg_q.max_distance    <= cfg_data_i[DistW-1:0];
        CfgFreshnessLimit: cfg_q.freshness_limit <= cfg_data_i[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  tlmf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .in_data_i (in_data_i),
    .job_o     (front_job)
  );

  tlmf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_data_i (front_job),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_job)
  );

  tlmf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tank_capacity_i (cfg_q.tank_capacity),
    .job_valid_i     (queue_valid),
    .job_i           (queue_job),
    .job_pop_o       (queue_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_o      (out_data_o)
  );

endmodule

`default_nettype wire

// ===== src/tlmf_checker.sv =====
// ----------------------------------------------------------------------------
// Tank level filter port checker
// Watches the output channel of the level filter for protocol and
// consistency errors.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmf_checker
  import tlmf_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire tlmf_out_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output valid dropped during a stalled transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Output payload changed during a stalled transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.level_known == (out_data_o.level_status != StatusUnavail)))
    else $error("Level known disagrees with the status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.level_known |->
      (out_data_o.fill_fraction == '0) && (out_data_o.volume == '0))
    else $error("Unknown level carries a fraction or volume.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fill_fraction <= FractionOne))
    else $error("Fill fraction exceeds one.");

endmodule

bind tank_level_median_filter tlmf_checker u_tlmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== test/tank_level_median_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank level median filter testbench
// Sends distance samples and status ticks through the valid/stall input with
// random gaps and output stalls. It predicts each result from its own copy of
// the window, calibration and freshness state, and compares every field of
// every output transfer in order.
// ----------------------------------------------------------------------------

module tank_level_median_filter_tb;
  import tlmf_pkg::*;

  class level_checker;
    tlmf_cfg_t        regs;
    logic [DistW-1:0] window [3];
    int unsigned      write_slot;
    int unsigned      held_count;
    logic [TimeW-1:0] last_accept_time;
    logic [DistW-1:0] filtered_value;
    tlmf_out_t        pending_levels [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      stored;
    int unsigned      stale_seen;

    function new();
      regs.full_distance   = FullDistanceRst;
      regs.empty_distance  = EmptyDistanceRst;
      regs.tank_capacity   = TankCapacityRst;
      regs.min_distance    = MinDistanceRst;
      regs.max_distance    = MaxDistanceRst;
      regs.freshness_limit = FreshnessLimitRst;
      write_slot       = 0;
      held_count       = 0;
      last_accept_time = '0;
      filtered_value   = '0;
      mismatches       = 0;
      checked          = 0;
      stored           = 0;
      stale_seen       = 0;
    endfunction

    function void set_reg(cfg_index_e idx, logic [CfgW-1:0] value);
      case (idx)
        CfgFullDistance:   regs.full_distance   = value[DistW-1:0];
        CfgEmptyDistance:  regs.empty_distance  = value[DistW-1:0];
        CfgTankCapacity:   regs.tank_capacity   = value[DistW-1:0];
        CfgMinDistance:    regs.min_distance    = value[DistW-1:0];
        CfgMaxDistance:    regs.max_distance    = value[DistW-1:0];
        CfgFreshnessLimit: regs.freshness_limit = value[TimeW-1:0];
        default: ;
      endcase
    endfunction

    function tlmf_out_t predict_level(tlmf_in_t s);
      tlmf_out_t        r;
      logic [DistW-1:0] a, b, c, lo, hi;
      logic [DistW:0]   pair_sum;
      logic [TimeW-1:0] age;
      longint unsigned  numer, denom, fraction, vol;
      bit               cal_ok;
      r = '0;
      cal_ok = regs.full_distance < regs.empty_distance;
      if (s.sample_present && s.sample_finite && s.distance >= regs.min_distance &&
          s.distance <= regs.max_distance) begin
        window[write_slot] = s.distance;
        write_slot = (write_slot + 1) % 3;
        if (held_count < 3) held_count++;
        last_accept_time = s.time_ms;
        a = window[0];
        b = window[1];
        c = window[2];
        if (held_count == 1) begin
          filtered_value = a;
        end else if (held_count == 2) begin
          pair_sum = {1'b0, a} + {1'b0, b};
          filtered_value = pair_sum[DistW:1];
        end else begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          if (c <= lo) filtered_value = lo;
          else if (c >= hi) filtered_value = hi;
          else filtered_value = c;
        end
        r.accepted = 1'b1;
        stored++;
      end
      age = s.time_ms - last_accept_time;
      if (held_count == 0 || !cal_ok) r.level_status = StatusUnavail;
      else if (age > regs.freshness_limit) r.level_status = StatusStale;
      else r.level_status = StatusValid;
      r.filtered_distance = filtered_value;
      if (held_count != 0 && cal_ok) begin
        r.level_known = 1'b1;
        if (filtered_value >= regs.empty_distance) begin
          fraction = 0;
        end else if (filtered_value <= regs.full_distance) begin
          fraction = FractionOne;
        end else begin
          numer = regs.empty_distance - filtered_value;
          denom = regs.empty_distance - regs.full_distance;
          fraction = (numer << 16) / denom;
          if (fraction > FractionOne) fraction = FractionOne;
        end
        vol = fraction * regs.tank_capacity;
        vol = vol >> 16;
        if (vol > 64'hFFFF) vol = 64'hFFFF;
        r.fill_fraction = fraction[FracW-1:0];
        r.volume = vol[DistW-1:0];
      end
      return r;
    endfunction

    function void note_sample(tlmf_in_t s);
      pending_levels.push_back(predict_level(s));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [16:0] got, logic [16:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                  checked, name, got, want));
      end
    endtask

    task check_level(tlmf_out_t got);
      tlmf_out_t want;
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing pending", got));
        return;
      end
      want = pending_levels.pop_front();
      checked++;
      if (want.level_status == StatusStale) stale_seen++;
      compare_field("accepted", got.accepted, want.accepted);
      compare_field("level_status", got.level_status, want.level_status);
      compare_field("filtered_distance", got.filtered_distance, want.filtered_distance);
      compare_field("level_known", got.level_known, want.level_known);
      compare_field("fill_fraction", got.fill_fraction, want.fill_fraction);
      compare_field("volume", got.volume, want.volume);
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tlmf_in_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tlmf_out_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgFullDistance;
  logic [CfgW-1:0]    cfg_data  = '0;

  level_checker     chk = new();
  bit               steady = 1'b0;
  logic [TimeW-1:0] clock_ms = '0;
  int unsigned      sent = 0;
  int unsigned      settings_used = 0;

  tank_level_median_filter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still pending.", chk.pending_levels.size());
    $display("simulation failed");
    $finish;
  end

  function automatic tlmf_in_t sample(logic [DistW-1:0] dist_val, logic present,
                                      logic finite, logic [TimeW-1:0] t);
    tlmf_in_t s;
    s.distance       = dist_val;
    s.sample_present = present;
    s.sample_finite  = finite;
    s.time_ms        = t;
    return s;
  endfunction

  function automatic tlmf_in_t make_sample(int unsigned span_lo, int unsigned span_hi);
    tlmf_in_t    s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 90) clock_ms += $urandom_range(0, 1500);
    else if (pick < 96) clock_ms += $urandom_range(1500, 100000);
    else clock_ms += $urandom;
    s.time_ms        = clock_ms;
    s.sample_present = ($urandom_range(0, 99) >= 8);
    s.sample_finite  = ($urandom_range(0, 99) >= 6);
    if ($urandom_range(0, 99) < 85) s.distance = 16'($urandom_range(span_lo, span_hi));
    else s.distance = 16'($urandom);
    return s;
  endfunction

  task automatic send_sample(tlmf_in_t s);
    int unsigned gap;
    logic        ready;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do begin
      @(negedge clk);
      ready = !in_stall;
      @(posedge clk);
    end while (!ready);
    chk.note_sample(s);
    sent++;
  endtask

  task automatic drain_levels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chk.set_reg(idx, value);
  endtask

  task automatic configure(logic [DistW-1:0] full_d, logic [DistW-1:0] empty_d,
                           logic [DistW-1:0] cap, logic [DistW-1:0] min_d,
                           logic [DistW-1:0] max_d, logic [TimeW-1:0] limit);
    drain_levels();
    repeat (4) @(posedge clk);
    write_reg(CfgFullDistance,   {16'($urandom), full_d});
    write_reg(CfgEmptyDistance,  {16'($urandom), empty_d});
    write_reg(CfgTankCapacity,   {16'($urandom), cap});
    write_reg(CfgMinDistance,    {16'($urandom), min_d});
    write_reg(CfgMaxDistance,    {16'($urandom), max_d});
    write_reg(CfgFreshnessLimit, limit);
    settings_used++;
  endtask

  initial begin
    tlmf_out_t   seen;
    int unsigned hold;
    logic        took;
    @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        seen = out_data;
        @(posedge clk);
      end while (!took);
      chk.check_level(seen);
    end
  end

  initial begin
    int unsigned      phase, n, pressure_at, span_lo, span_hi;
    logic [DistW-1:0] full_d, empty_d, cap, min_d, max_d;
    logic [TimeW-1:0] limit;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration is invalid, so everything reads unavailable.
    send_sample(sample(16'd0, 1'b0, 1'b1, 32'd0));
    send_sample(sample(16'd100, 1'b1, 1'b0, 32'd5));
    send_sample(sample(16'hFFFF, 1'b1, 1'b1, 32'd10));

    configure(16'd1600, 16'd32000, 16'd8000, 16'd800, 16'd40000, 32'd1000);
    send_sample(sample(16'd0, 1'b0, 1'b0, 32'd20));
    send_sample(sample(16'd799, 1'b1, 1'b1, 32'd30));
    send_sample(sample(16'd40001, 1'b1, 1'b1, 32'd40));
    send_sample(sample(16'd800, 1'b1, 1'b1, 32'd50));
    send_sample(sample(16'd40000, 1'b1, 1'b1, 32'd60));
    send_sample(sample(16'd1000, 1'b1, 1'b1, 32'd70));
    send_sample(sample(16'd20000, 1'b1, 1'b1, 32'd80));
    send_sample(sample(16'd16000, 1'b1, 1'b1, 32'd90));
    send_sample(sample(16'd0, 1'b0, 1'b1, 32'd1090));
    send_sample(sample(16'd0, 1'b0, 1'b1, 32'd1091));
    send_sample(sample(16'd5000, 1'b1, 1'b0, 32'd1200));
    send_sample(sample(16'd12000, 1'b1, 1'b1, 32'hFFFF_FF00));
    send_sample(sample(16'd0, 1'b0, 1'b1, 32'h0000_0100));

    configure(16'd9000, 16'd9000, 16'd8000, 16'd800, 16'd40000, 32'd1000);
    send_sample(sample(16'd9000, 1'b1, 1'b1, 32'h0000_0200));
    configure(16'd30000, 16'd2000, 16'd8000, 16'd5000, 16'd4000, 32'd1000);
    send_sample(sample(16'd4500, 1'b1, 1'b1, 32'h0000_0300));
    send_sample(sample(16'd0, 1'b0, 1'b1, 32'h0000_0400));

    for (phase = 0; phase < 8; phase++) begin
      span_lo = 0;
      span_hi = 65535;
      case (phase)
        0: begin
          full_d = 16'd0; empty_d = 16'hFFFF; cap = 16'hFFFF;
          min_d = 16'd0; max_d = 16'hFFFF; limit = 32'hFFFF_FFFF;
        end
        1: begin
          full_d = 16'hFFFF; empty_d = 16'd0; cap = 16'd0;
          min_d = 16'hFFFF; max_d = 16'd0; limit = 32'd0;
        end
        2: begin
          full_d = 16'($urandom_range(1000, 60000)); empty_d = full_d; cap = 16'($urandom);
          min_d = 16'd0; max_d = 16'hFFFF; limit = $urandom_range(0, 3000);
        end
        default: begin
          full_d  = 16'($urandom_range(0, 30000));
          empty_d = 16'($urandom_range(full_d + 1, 65535));
          cap     = 16'($urandom);
          min_d   = 16'($urandom_range(0, full_d));
          max_d   = 16'($urandom_range(empty_d, 65535));
          limit   = (phase == 7) ? $urandom : $urandom_range(0, 3000);
          span_lo = (full_d > 300) ? full_d - 300 : 0;
          span_hi = (empty_d < 65235) ? empty_d + 300 : 65535;
        end
      endcase
      configure(full_d, empty_d, cap, min_d, max_d, limit);
      clock_ms = $urandom;
      pressure_at = $urandom_range(20, 200);
      for (n = 0; n < 220; n++) begin
        if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        if (n == pressure_at) drain_levels();
        send_sample(make_sample(span_lo, span_hi));
      end
    end

    steady = 1'b0;
    drain_levels();
    repeat (30) @(posedge clk);
    $display("Covered %0d input transfers over %0d register settings.", sent, settings_used);
    $display("%0d samples entered the window and %0d results were stale.",
             chk.stored, chk.stale_seen);
    if (chk.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== tank_level_median_filter.f =====
src/tlmf_pkg.sv
src/tlmf_front.sv
src/tlmf_queue.sv
src/tlmf_back.sv
src/tank_level_median_filter.sv
src/tlmf_checker.sv
test/tank_level_median_filter_tb.sv
